### design/bfc_pkg.sv
// Shared types and constants for the Blowfish engine.
package bfc_pkg;
    localparam int unsigned P_WORDS   = 18;
    localparam int unsigned NUM_ROUNDS = 16;
    localparam int unsigned S_WORDS   = 1024;
    localparam int unsigned S_AW      = 10;
    localparam int unsigned P_AW      = 5;
    localparam int unsigned IDX_W     = 11;

    typedef enum logic [2:0] {
        OP_LOAD_TABLE = 3'd0,
        OP_LOAD_KEY   = 3'd1,
        OP_EXPAND     = 3'd2,
        OP_ENCRYPT    = 3'd3,
        OP_DECRYPT    = 3'd4
    } op_t;

    // Input item as carried on the slave tdata.
    typedef struct packed {
        logic [31:0] block_right;
        logic [31:0] block_left;
        logic [7:0]  key_byte;
        logic [31:0] table_word;
        logic [IDX_W-1:0] index;
        logic [2:0]  operation;
    } item_t;

    typedef struct packed {
        logic [31:0] out_right;
        logic [31:0] out_left;
    } result_t;
endpackage

### design/blowfish_cipher_with_key_schedule_core.sv
// Blowfish engine top level: table load, key load, key expansion, encrypt, decrypt.
// Each transfer yields one result. Encrypt and decrypt run 16 rounds, each over states
// ROUND_A and ROUND_B for the registered S-box read, then ST_FINAL and output; key
// expansion XORs the key into P, then 521 encryptions refill P and S. The block takes
// no new item until the result is taken. No clearing pass: tables are valid only once written.
module blowfish_cipher_with_key_schedule_core #(
    parameter int unsigned MAX_KEY_BYTES = 56
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], index[13:3], table_word[45:14], key_byte[53:46],
    // block_left[85:54], block_right[117:86], unused [119:118]
    input  logic [119:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_left[31:0], out_right[63:32]
    output logic [63:0] m_tdata
);
    import bfc_pkg::*;

    localparam int unsigned KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int unsigned KLW = $clog2(MAX_KEY_BYTES + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_KEYX, ST_ROUND_A, ST_ROUND_B, ST_FINAL, ST_STORE, ST_OUT
    } state_t;

    state_t       state_reg;
    item_t        item;
    logic [5:0]   klen_reg;
    logic [31:0]  p_reg [P_WORDS];
    logic [7:0]   key_mem [MAX_KEY_BYTES];
    logic [7:0]   key_q_reg;
    logic [KW-1:0] kptr_reg;
    logic [1:0]   kbyte_reg;
    logic [31:0]  kdata_reg;
    logic [P_AW-1:0] pi_reg;
    logic [4:0]   round_reg;
    logic [31:0]  xl_reg, xr_reg;
    logic         expand_reg, dir_reg, kfirst_reg;
    logic [10:0]  wcnt_reg;
    logic [63:0]  res_reg;
    logic         s_wr;
    logic [9:0]   s_waddr;
    logic [31:0]  s_wdata;
    logic [31:0]  f_out, t_word;
    logic [KLW-1:0] klen_sat;
    logic [P_AW-1:0] pidx;

    assign item = item_t'(s_tdata[$bits(item_t)-1:0]);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = res_reg;

    always_comb
    begin
        if (klen_reg == 6'd0)
            klen_sat = KLW'(1);
        else if (32'(klen_reg) > MAX_KEY_BYTES)
            klen_sat = KLW'(MAX_KEY_BYTES);
        else
            klen_sat = KLW'(klen_reg);
    end

    assign pidx   = dir_reg ? P_AW'(P_WORDS - 1) - P_AW'(round_reg) : P_AW'(round_reg);
    assign t_word = p_reg[pidx] ^ xl_reg;

    // Load-table writes go in only from idle; expansion stores one half per cycle.
    always_comb
    begin
        s_wr = 1'b0;
        s_waddr = 10'(item.index - IDX_W'(P_WORDS));
        s_wdata = item.table_word;
        if (state_reg == ST_IDLE && s_tvalid && item.operation == OP_LOAD_TABLE
            && item.index >= IDX_W'(P_WORDS) && item.index < IDX_W'(P_WORDS + S_WORDS))
            s_wr = 1'b1;
        else if (state_reg == ST_STORE && wcnt_reg >= 11'(P_WORDS))
        begin
            s_wr = 1'b1;
            s_waddr = 10'(wcnt_reg - 11'(P_WORDS));
            s_wdata = xl_reg;
        end
    end

    bfc_sbox_mem u_sbox (
        .clk     (clk),
        .wr_en   (s_wr),
        .wr_addr (s_waddr),
        .wr_data (s_wdata),
        .rd_word (t_word),
        .f_out   (f_out)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid && item.operation == OP_LOAD_KEY
            && 32'(item.index) < MAX_KEY_BYTES)
            key_mem[item.index[KW-1:0]] <= item.key_byte;
        key_q_reg <= key_mem[kptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            klen_reg   <= 6'd16;
            expand_reg <= 1'b0;
            dir_reg    <= 1'b0;
            kfirst_reg <= 1'b0;
            round_reg  <= '0;
            wcnt_reg   <= '0;
            kptr_reg   <= '0;
            kbyte_reg  <= '0;
            pi_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_valid)
                        klen_reg <= cfg_data;
                    if (s_tvalid)
                    begin
                        res_reg <= '0;
                        xl_reg <= item.block_left;
                        xr_reg <= item.block_right;
                        round_reg <= '0;
                        dir_reg <= (item.operation == OP_DECRYPT);
                        expand_reg <= 1'b0;
                        state_reg <= ST_OUT;
                        if (item.operation == OP_LOAD_TABLE && item.index < IDX_W'(P_WORDS))
                            p_reg[item.index[P_AW-1:0]] <= item.table_word;
                        if (item.operation == OP_ENCRYPT || item.operation == OP_DECRYPT)
                            state_reg <= ST_ROUND_A;
                        if (item.operation == OP_EXPAND)
                        begin
                            state_reg <= ST_KEYX;
                            kptr_reg <= '0;
                            kbyte_reg <= '0;
                            pi_reg <= '0;
                            kfirst_reg <= 1'b1;
                        end
                    end
                end
                // One key byte per cycle; key_q_reg is the registered read of key_mem[kptr_reg].
                ST_KEYX:
                begin
                    kfirst_reg <= 1'b0;
                    if (!kfirst_reg)
                    begin
                        kdata_reg <= {kdata_reg[23:0], key_q_reg};
                        kbyte_reg <= kbyte_reg + 2'd1;
                        if (kbyte_reg == 2'd3)
                        begin
                            p_reg[pi_reg] <= p_reg[pi_reg] ^ {kdata_reg[23:0], key_q_reg};
                            pi_reg <= pi_reg + P_AW'(1);
                            if (pi_reg == P_AW'(P_WORDS - 1))
                            begin
                                xl_reg <= '0;
                                xr_reg <= '0;
                                round_reg <= '0;
                                dir_reg <= 1'b0;
                                expand_reg <= 1'b1;
                                wcnt_reg <= '0;
                                state_reg <= ST_ROUND_A;
                            end
                        end
                    end
                    if (32'(kptr_reg) + 1 >= 32'(klen_sat))
                        kptr_reg <= '0;
                    else
                        kptr_reg <= kptr_reg + KW'(1);
                end
                ST_ROUND_A:
                    state_reg <= ST_ROUND_B;
                ST_ROUND_B:
                begin
                    xl_reg <= f_out ^ xr_reg;
                    xr_reg <= p_reg[pidx] ^ xl_reg;
                    round_reg <= round_reg + 5'd1;
                    state_reg <= (round_reg == 5'(NUM_ROUNDS - 1)) ? ST_FINAL : ST_ROUND_A;
                end
                ST_FINAL:
                begin
                    if (dir_reg)
                    begin
                        xl_reg <= p_reg[0] ^ xr_reg;
                        xr_reg <= xl_reg ^ p_reg[1];
                    end
                    else
                    begin
                        xl_reg <= p_reg[P_WORDS-1] ^ xr_reg;
                        xr_reg <= xl_reg ^ p_reg[P_WORDS-2];
                    end
                    if (!expand_reg)
                    begin
                        res_reg <= dir_reg ? {xl_reg ^ p_reg[1], p_reg[0] ^ xr_reg}
                                           : {xl_reg ^ p_reg[P_WORDS-2], p_reg[P_WORDS-1] ^ xr_reg};
                        state_reg <= ST_OUT;
                    end
                    else
                        state_reg <= ST_STORE;
                end
                // Stores the left half, then the right half, into P or S.
                ST_STORE:
                begin
                    if (wcnt_reg < 11'(P_WORDS))
                        p_reg[wcnt_reg[P_AW-1:0]] <= xl_reg;
                    wcnt_reg <= wcnt_reg + 11'd1;
                    xl_reg <= xr_reg;
                    xr_reg <= xl_reg;
                    if (wcnt_reg[0])
                    begin
                        round_reg <= '0;
                        state_reg <= ST_ROUND_A;
                        if (wcnt_reg == 11'(P_WORDS + S_WORDS - 1))
                            state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                    if (m_tready)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

### design/bfc_sbox_mem.sv
// Four S-boxes in four banks, read in parallel with registered data.
module bfc_sbox_mem
(
    input  logic        clk,
    input  logic        wr_en,
    input  logic [9:0]  wr_addr,
    input  logic [31:0] wr_data,
    input  logic [31:0] rd_word,
    output logic [31:0] f_out
);
    import bfc_pkg::*;

    logic [31:0] bank0 [256];
    logic [31:0] bank1 [256];
    logic [31:0] bank2 [256];
    logic [31:0] bank3 [256];
    logic [31:0] q0_reg, q1_reg, q2_reg, q3_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_addr[9:8] == 2'd0) bank0[wr_addr[7:0]] <= wr_data;
        if (wr_en && wr_addr[9:8] == 2'd1) bank1[wr_addr[7:0]] <= wr_data;
        if (wr_en && wr_addr[9:8] == 2'd2) bank2[wr_addr[7:0]] <= wr_data;
        if (wr_en && wr_addr[9:8] == 2'd3) bank3[wr_addr[7:0]] <= wr_data;
        q0_reg <= bank0[rd_word[31:24]];
        q1_reg <= bank1[rd_word[23:16]];
        q2_reg <= bank2[rd_word[15:8]];
        q3_reg <= bank3[rd_word[7:0]];
    end

    assign f_out = ((q0_reg + q1_reg) ^ q2_reg) + q3_reg;
endmodule

### design/bfc_checker.sv
// Port-level checks for the Blowfish engine, bound to the top level.
module bfc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        cfg_ready
);
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready) else $error("accepted two items back to back");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == s_tready) else $error("config port open while busy");
endmodule

bind blowfish_cipher_with_key_schedule_core bfc_checker u_bfc_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .cfg_ready(cfg_ready)
);
